FILE: design/harmonic_bond_energy_gradient_assert.svh
// Assertion macros shared by the harmonic bond energy and gradient block.
// Used by modules that see clk and rst_n; no other dependencies.
`ifndef HARMONIC_BOND_ENERGY_GRADIENT_ASSERT_SVH
`define HARMONIC_BOND_ENERGY_GRADIENT_ASSERT_SVH
`ifndef SYNTHESIS
`define HBEG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBEG_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HBEG_ASSERT(lbl, prop, msg)
`define HBEG_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/hbeg_pkg.sv
`timescale 1ns / 1ps
// Types, constants and iteration steps of the harmonic bond energy block.
// No dependencies.
package hbeg_pkg;

    localparam int COORD_W       = 20;
    localparam int MAG_W         = 20;
    localparam int LEN_W         = 21;
    localparam int SUM_W         = 42;
    localparam int ROOT_REM_W    = 24;
    localparam int SQ_STAGES     = 7;
    localparam int SQ_PER_STAGE  = 3;
    localparam int K_W           = 24;
    localparam int W_W           = 24;
    localparam int ENERGY_W      = 48;
    localparam int GRAD_W        = 40;
    localparam int GM_W          = 52;
    localparam int NUM_W         = 72;
    localparam int DIV_REM_W     = 22;
    localparam int DIV_STAGES    = 10;
    localparam int DIV_PER_STAGE = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [LEN_W-2:0] TRANS_LEN_RST = 20'd3891;
    localparam logic [K_W-1:0]   TRANS_K_RST   = 24'd227840;
    localparam logic [LEN_W-2:0] CIS_LEN_RST   = 20'd3021;
    localparam logic [K_W-1:0]   CIS_K_RST     = 24'd21760;
    localparam logic [W_W-1:0]   WEIGHT_RST    = 24'd65536;

    localparam logic [GRAD_W-1:0] GRAD_POS_SAT = 40'h7F_FFFF_FFFF;
    localparam logic [GRAD_W-1:0] GRAD_NEG_SAT = 40'h80_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANS_LEN = 3'd0,
        CFG_TRANS_K   = 3'd1,
        CFG_CIS_LEN   = 3'd2,
        CFG_CIS_K     = 3'd3,
        CFG_WEIGHT    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        logic [LEN_W-2:0]      l0;
        logic [K_W-1:0]        k;
    } bond_item_t;

    typedef struct packed {
        bond_item_t          item;
        logic [LEN_W-1:0]    len;
        logic                dneg;
        logic                deg;
        logic [LEN_W-1:0]    dmag;
        logic [ENERGY_W-1:0] energy;
        logic [2:0]          ovf;
    } bond_carry_t;

    typedef struct packed {
        logic [ROOT_REM_W-1:0] rem;
        logic [LEN_W-1:0]      root;
        logic [SUM_W-1:0]      rad;
    } sqrt_state_t;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [GRAD_W-1:0]    quo;
    } div_state_t;

    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
        sqrt_state_t n;
        logic [ROOT_REM_W-1:0] r;
        logic [ROOT_REM_W-1:0] t;
        r = {s.rem[ROOT_REM_W-3:0], s.rad[SUM_W-1 -: 2]};
        t = ROOT_REM_W'({s.root, 2'b01});
        n.rad = {s.rad[SUM_W-3:0], 2'b00};
        if (r >= t)
        begin
            n.rem  = r - t;
            n.root = {s.root[LEN_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = r;
            n.root = {s.root[LEN_W-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic div_state_t div_step(input div_state_t s, input logic [LEN_W-1:0] len);
        div_state_t n;
        logic [DIV_REM_W-1:0] r;
        r = {s.rem[DIV_REM_W-2:0], s.quo[GRAD_W-1]};
        n.quo = {s.quo[GRAD_W-2:0], 1'b0};
        if (r >= DIV_REM_W'(len))
        begin
            n.rem    = r - DIV_REM_W'(len);
            n.quo[0] = 1'b1;
        end
        else
        begin
            n.rem = r;
        end
        return n;
    endfunction

endpackage

FILE: design/hbeg_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, request intake, difference vector and
// cis or trans parameter selection. Depends on hbeg_pkg.
module hbeg_front import hbeg_pkg::*; #(
    parameter int INDEX_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] first_z,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic signed [COORD_W-1:0] second_z,
    input  logic                   cis_bond,
    input  logic [INDEX_BITS-1:0]  first_index,
    input  logic [INDEX_BITS-1:0]  second_index,
    input  logic                   q_full,
    output logic                   q_push,
    output bond_item_t             q_item,
    output logic [INDEX_BITS-1:0]  q_idx1,
    output logic [INDEX_BITS-1:0]  q_idx2,
    output logic [W_W-1:0]         weight
);

    logic [LEN_W-2:0] trans_len_reg;
    logic [K_W-1:0]   trans_k_reg;
    logic [LEN_W-2:0] cis_len_reg;
    logic [K_W-1:0]   cis_k_reg;
    logic [W_W-1:0]   weight_reg;

    logic                  valid_reg;
    bond_item_t            item_reg;
    bond_item_t            item_next;
    logic [INDEX_BITS-1:0] idx1_reg;
    logic [INDEX_BITS-1:0] idx2_reg;
    logic                  accept;

    logic signed [COORD_W:0] diff [3];

    assign cfg_ready = 1'b1;
    assign weight    = weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_len_reg <= TRANS_LEN_RST;
            trans_k_reg   <= TRANS_K_RST;
            cis_len_reg   <= CIS_LEN_RST;
            cis_k_reg     <= CIS_K_RST;
            weight_reg    <= WEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TRANS_LEN: trans_len_reg <= cfg_data[LEN_W-2:0];
                CFG_TRANS_K:   trans_k_reg   <= cfg_data;
                CFG_CIS_LEN:   cis_len_reg   <= cfg_data[LEN_W-2:0];
                CFG_CIS_K:     cis_k_reg     <= cfg_data;
                CFG_WEIGHT:    weight_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;

    always_comb
    begin
        diff[0] = (COORD_W+1)'(first_x) - (COORD_W+1)'(second_x);
        diff[1] = (COORD_W+1)'(first_y) - (COORD_W+1)'(second_y);
        diff[2] = (COORD_W+1)'(first_z) - (COORD_W+1)'(second_z);
        for (int i = 0; i < 3; i++)
        begin
            item_next.neg[i] = diff[i][COORD_W];
            item_next.mag[i] = diff[i][COORD_W] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
        end
        item_next.l0 = cis_bond ? cis_len_reg : trans_len_reg;
        item_next.k  = cis_bond ? cis_k_reg : trans_k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            idx1_reg <= first_index;
            idx2_reg <= second_index;
        end
    end

    assign q_item = item_reg;
    assign q_idx1 = idx1_reg;
    assign q_idx2 = idx2_reg;

endmodule

FILE: design/hbeg_queue.sv
`timescale 1ns / 1ps
// Short request queue between the front end and the arithmetic pipeline.
// Depends on hbeg_pkg and the assertion macro header.
module hbeg_queue import hbeg_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         q_full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         q_empty
);

`include "harmonic_bond_energy_gradient_assert.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_full  = count_reg == CNT_W'(DEPTH);
    assign q_empty = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `HBEG_NEVER(a_queue_no_overflow, wr_en && q_full, "queue written while full")
    `HBEG_NEVER(a_queue_no_underflow, rd_en && q_empty, "queue read while empty")
    `HBEG_ASSERT(a_queue_count_range, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

FILE: design/hbeg_back.sv
`timescale 1ns / 1ps
// Arithmetic pipeline: bond length, energy, gradient magnitude and division.
// Depends on hbeg_pkg and the assertion macro header.
module hbeg_back import hbeg_pkg::*; #(
    parameter int INDEX_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  bond_item_t             q_item,
    input  logic [INDEX_BITS-1:0]  q_idx1,
    input  logic [INDEX_BITS-1:0]  q_idx2,
    output logic                   q_pop,
    input  logic [W_W-1:0]         weight,
    output logic                   empty,
    input  logic                   pop,
    output logic [ENERGY_W-1:0]    bond_energy_out,
    output logic [2:0][GRAD_W-1:0] grad_out,
    output logic [INDEX_BITS-1:0]  first_index_out,
    output logic [INDEX_BITS-1:0]  second_index_out,
    output logic                   degenerate
);

`include "harmonic_bond_energy_gradient_assert.svh"

    localparam int NST    = 27;
    localparam int ST_LEN = 9;
    localparam int ST_DIV = 15;
    localparam int ST_OUT = NST - 1;

    logic                  en;
    logic [NST-1:0]        valid_reg;
    bond_carry_t           carry_reg  [NST];
    bond_carry_t           carry_next [NST];
    logic [INDEX_BITS-1:0] idx1_reg   [NST];
    logic [INDEX_BITS-1:0] idx2_reg   [NST];

    logic [2*MAG_W-1:0]    sq_reg [3];
    logic [SUM_W-1:0]      sum_reg;
    sqrt_state_t           sqs_reg  [SQ_STAGES];
    sqrt_state_t           sqs_next [SQ_STAGES];
    logic [2*LEN_W-1:0]    dsq_reg;
    logic [K_W+LEN_W-1:0]  kd_reg;
    logic [K_W+LEN_W-1:0]  e_lo_reg;
    logic [K_W+LEN_W-1:0]  e_hi_reg;
    logic [W_W+22:0]       g_lo_reg;
    logic [W_W+21:0]       g_hi_reg;
    logic [GM_W-1:0]       gm_reg;
    logic [GM_W/2+MAG_W-1:0] p_lo_reg [3];
    logic [GM_W/2+MAG_W-1:0] p_hi_reg [3];
    logic [NUM_W-1:0]      num_reg [3];
    div_state_t            divs_reg  [DIV_STAGES+1][3];
    div_state_t            divs_next [DIV_STAGES+1][3];
    logic [GRAD_W-1:0]     gout_reg  [3];
    logic [GRAD_W-1:0]     gout_next [3];

    logic [2*K_W+2*LEN_W-1:0] efull;
    logic [K_W+LEN_W+W_W-1:0] gprod;
    logic [LEN_W-1:0]         l0_ext;

    assign en    = !valid_reg[ST_OUT] || pop;
    assign q_pop = en && !q_empty;
    assign empty = !valid_reg[ST_OUT];

    always_comb
    begin
        carry_next[0]      = '0;
        carry_next[0].item = q_item;
        for (int j = 1; j < NST; j++)
        begin
            carry_next[j] = carry_reg[j-1];
        end

        l0_ext = {1'b0, carry_reg[ST_LEN-1].item.l0};
        carry_next[ST_LEN].len  = sqs_reg[SQ_STAGES-1].root;
        carry_next[ST_LEN].deg  = sqs_reg[SQ_STAGES-1].root == '0;
        carry_next[ST_LEN].dneg = sqs_reg[SQ_STAGES-1].root < l0_ext;
        carry_next[ST_LEN].dmag = (sqs_reg[SQ_STAGES-1].root < l0_ext)
                                  ? l0_ext - sqs_reg[SQ_STAGES-1].root
                                  : sqs_reg[SQ_STAGES-1].root - l0_ext;

        efull = (2*K_W+2*LEN_W)'(e_lo_reg) + {e_hi_reg, 21'b0};
        gprod = (K_W+LEN_W+W_W)'(g_lo_reg) + {g_hi_reg, 23'b0};
        carry_next[12].energy = (|efull[2*K_W+2*LEN_W-1:60]) ? '1 : efull[59:12];

        for (int i = 0; i < 3; i++)
        begin
            carry_next[ST_DIV].ovf[i] = num_reg[i][NUM_W-1:GRAD_W]
                                        >= (NUM_W-GRAD_W)'(carry_reg[ST_DIV-1].len);
            divs_next[0][i].rem = num_reg[i][GRAD_W+DIV_REM_W-1:GRAD_W];
            divs_next[0][i].quo = num_reg[i][GRAD_W-1:0];
        end

        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                divs_next[s][i] = divs_reg[s-1][i];
                for (int b = 0; b < DIV_PER_STAGE; b++)
                begin
                    divs_next[s][i] = div_step(divs_next[s][i], carry_reg[ST_DIV+s-1].len);
                end
            end
        end

        sqs_next[0] = '{rem: '0, root: '0, rad: sum_reg};
        for (int b = 0; b < SQ_PER_STAGE; b++)
        begin
            sqs_next[0] = sqrt_step(sqs_next[0]);
        end
        for (int s = 1; s < SQ_STAGES; s++)
        begin
            sqs_next[s] = sqs_reg[s-1];
            for (int b = 0; b < SQ_PER_STAGE; b++)
            begin
                sqs_next[s] = sqrt_step(sqs_next[s]);
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            if (carry_reg[ST_OUT-1].deg)
            begin
                gout_next[i] = '0;
            end
            else if (carry_reg[ST_OUT-1].dneg ^ carry_reg[ST_OUT-1].item.neg[i])
            begin
                gout_next[i] = (carry_reg[ST_OUT-1].ovf[i]
                                || divs_reg[DIV_STAGES][i].quo > GRAD_NEG_SAT)
                               ? GRAD_NEG_SAT : ~divs_reg[DIV_STAGES][i].quo + 1'b1;
            end
            else
            begin
                gout_next[i] = (carry_reg[ST_OUT-1].ovf[i]
                                || divs_reg[DIV_STAGES][i].quo[GRAD_W-1])
                               ? GRAD_POS_SAT : divs_reg[DIV_STAGES][i].quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], !q_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NST; j++)
            begin
                carry_reg[j] <= carry_next[j];
            end
            idx1_reg[0] <= q_idx1;
            idx2_reg[0] <= q_idx2;
            for (int j = 1; j < NST; j++)
            begin
                idx1_reg[j] <= idx1_reg[j-1];
                idx2_reg[j] <= idx2_reg[j-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= q_item.mag[i] * q_item.mag[i];
            end
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            for (int s = 0; s < SQ_STAGES; s++)
            begin
                sqs_reg[s] <= sqs_next[s];
            end
            dsq_reg  <= carry_reg[ST_LEN].dmag * carry_reg[ST_LEN].dmag;
            kd_reg   <= carry_reg[ST_LEN].item.k * carry_reg[ST_LEN].dmag;
            e_lo_reg <= carry_reg[10].item.k * dsq_reg[LEN_W-1:0];
            e_hi_reg <= carry_reg[10].item.k * dsq_reg[2*LEN_W-1:LEN_W];
            g_lo_reg <= kd_reg[22:0] * weight;
            g_hi_reg <= kd_reg[K_W+LEN_W-1:23] * weight;
            gm_reg   <= gprod[K_W+LEN_W+W_W-1:17];
            for (int i = 0; i < 3; i++)
            begin
                p_lo_reg[i] <= gm_reg[GM_W/2-1:0] * carry_reg[12].item.mag[i];
                p_hi_reg[i] <= gm_reg[GM_W-1:GM_W/2] * carry_reg[12].item.mag[i];
                num_reg[i]  <= NUM_W'(p_lo_reg[i]) + {p_hi_reg[i], 26'b0};
                gout_reg[i] <= gout_next[i];
            end
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    divs_reg[s][i] <= divs_next[s][i];
                end
            end
        end
    end

    assign bond_energy_out  = carry_reg[ST_OUT].energy;
    assign degenerate       = carry_reg[ST_OUT].deg;
    assign first_index_out  = idx1_reg[ST_OUT];
    assign second_index_out = idx2_reg[ST_OUT];
    assign grad_out[0]      = gout_reg[0];
    assign grad_out[1]      = gout_reg[1];
    assign grad_out[2]      = gout_reg[2];

    `HBEG_ASSERT(a_back_take, q_pop |=> valid_reg[0], "request taken from queue was lost")
    `HBEG_ASSERT(a_back_hold, valid_reg[ST_OUT] && !pop |=> valid_reg[ST_OUT], "result dropped")
    `HBEG_ASSERT(a_back_degen, valid_reg[ST_OUT] && degenerate |-> grad_out == '0, "degenerate gradient")

endmodule

FILE: design/harmonic_bond_energy_gradient.sv
`timescale 1ns / 1ps
// Throughput: one bond per cycle; the arithmetic pipeline freezes only while a
// finished result waits and pop is low, and the four-entry queue absorbs the front.
// Reset: rst_n is asynchronous, clears all valid state and loads register defaults.
// Depends on hbeg_pkg, hbeg_front, hbeg_queue and hbeg_back.
module harmonic_bond_energy_gradient import hbeg_pkg::*; #(
    parameter int INDEX_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] first_z,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic signed [COORD_W-1:0] second_z,
    input  logic                      cis_bond,
    input  logic [INDEX_BITS-1:0]     first_index,
    input  logic [INDEX_BITS-1:0]     second_index,
    output logic                      empty,
    input  logic                      pop,
    output logic [ENERGY_W-1:0]       bond_energy_out,
    output logic signed [GRAD_W-1:0]  grad_x,
    output logic signed [GRAD_W-1:0]  grad_y,
    output logic signed [GRAD_W-1:0]  grad_z,
    output logic [INDEX_BITS-1:0]     first_index_out,
    output logic [INDEX_BITS-1:0]     second_index_out,
    output logic                      degenerate
);

    localparam int QW = $bits(bond_item_t) + 2 * INDEX_BITS;

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    bond_item_t            f_item;
    logic [INDEX_BITS-1:0] f_idx1;
    logic [INDEX_BITS-1:0] f_idx2;
    logic [QW-1:0]         q_rd;
    logic [W_W-1:0]        weight;
    logic [2:0][GRAD_W-1:0] grad_out;

    hbeg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .cis_bond     (cis_bond),
        .first_index  (first_index),
        .second_index (second_index),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (f_item),
        .q_idx1       (f_idx1),
        .q_idx2       (f_idx2),
        .weight       (weight)
    );

    hbeg_queue #(.W(QW), .DEPTH(4)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data ({f_item, f_idx1, f_idx2}),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd),
        .q_empty (q_empty)
    );

    hbeg_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_item           (q_rd[QW-1:2*INDEX_BITS]),
        .q_idx1           (q_rd[2*INDEX_BITS-1:INDEX_BITS]),
        .q_idx2           (q_rd[INDEX_BITS-1:0]),
        .q_pop            (q_pop),
        .weight           (weight),
        .empty            (empty),
        .pop              (pop),
        .bond_energy_out  (bond_energy_out),
        .grad_out         (grad_out),
        .first_index_out  (first_index_out),
        .second_index_out (second_index_out),
        .degenerate       (degenerate)
    );

    assign grad_x = grad_out[0];
    assign grad_y = grad_out[1];
    assign grad_z = grad_out[2];

endmodule

FILE: verif/bond_checker.sv
`timescale 1ns / 1ps
// Checker for the harmonic bond energy and gradient block: watches the configuration,
// request and result channels, predicts each result and compares it. Depends on hbeg_pkg.
module bond_checker import hbeg_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      push,
    input  logic                      full,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] first_z,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic signed [COORD_W-1:0] second_z,
    input  logic                      cis_bond,
    input  logic [11:0]               first_index,
    input  logic [11:0]               second_index,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [ENERGY_W-1:0]       bond_energy_out,
    input  logic signed [GRAD_W-1:0]  grad_x,
    input  logic signed [GRAD_W-1:0]  grad_y,
    input  logic signed [GRAD_W-1:0]  grad_z,
    input  logic [11:0]               first_index_out,
    input  logic [11:0]               second_index_out,
    input  logic                      degenerate,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [GRAD_W-1:0]   gx;
        logic [GRAD_W-1:0]   gy;
        logic [GRAD_W-1:0]   gz;
        logic [11:0]         idx1;
        logic [11:0]         idx2;
        logic                deg;
    } bond_result_t;

    logic [19:0] trans_len, cis_len;
    logic [23:0] trans_k, cis_k, weight;
    bond_result_t expected_bonds[$];

    assign pending = expected_bonds.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= n)
                root = root | (64'd1 << b);
        end
        return root;
    endfunction

    function automatic bond_result_t predict_bond();
        bond_result_t r;
        logic signed [21:0] delta[3];
        logic [20:0] mag[3];
        logic [63:0] sum, len, dmag;
        logic [19:0] l0;
        logic [23:0] k;
        logic dneg, neg;
        logic [127:0] energy_full, gm_full, q;
        logic [63:0] gm;
        logic [GRAD_W-1:0] g[3];
        delta[0] = 22'(first_x) - 22'(second_x);
        delta[1] = 22'(first_y) - 22'(second_y);
        delta[2] = 22'(first_z) - 22'(second_z);
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = delta[i] < 0 ? 21'(-delta[i]) : 21'(delta[i]);
            sum += 64'(mag[i]) * 64'(mag[i]);
        end
        len = int_sqrt(sum);
        l0 = cis_bond ? cis_len : trans_len;
        k = cis_bond ? cis_k : trans_k;
        dneg = len < 64'(l0);
        dmag = dneg ? 64'(l0) - len : len - 64'(l0);
        energy_full = (128'(k) * 128'(dmag * dmag)) >> 12;
        r.energy = energy_full > 128'hFFFF_FFFF_FFFF ? '1 : energy_full[47:0];
        gm_full = (128'(64'(2 * 64'(k) * dmag)) * 128'(weight)) >> 18;
        gm = gm_full[127:64] != 0 ? '1 : gm_full[63:0];
        for (int i = 0; i < 3; i++)
        begin
            g[i] = 0;
            if (sum != 0)
            begin
                neg = dneg != (delta[i] < 0);
                q = (128'(gm) * 128'(mag[i])) / 128'(len);
                if (neg)
                    g[i] = q > 128'h80_0000_0000 ? GRAD_NEG_SAT : 40'(-q);
                else
                    g[i] = q > 128'h7F_FFFF_FFFF ? GRAD_POS_SAT : q[39:0];
            end
        end
        r.gx = g[0];
        r.gy = g[1];
        r.gz = g[2];
        r.idx1 = first_index;
        r.idx2 = second_index;
        r.deg = sum == 0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bond_result_t e;
        if (!rst_n)
        begin
            trans_len = TRANS_LEN_RST;
            trans_k = TRANS_K_RST;
            cis_len = CIS_LEN_RST;
            cis_k = CIS_K_RST;
            weight = WEIGHT_RST;
            fail_count = 0;
            expected_bonds.delete();
        end
        else
        begin
            if (!empty && pop)
            begin
                if (expected_bonds.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_bonds.pop_front();
                    if (bond_energy_out !== e.energy)
                    begin
                        $error("bond_energy_out expected %0d got %0d", e.energy, bond_energy_out);
                        fail_count++;
                    end
                    if (grad_x !== e.gx)
                    begin
                        $error("grad_x expected %0h got %0h", e.gx, grad_x);
                        fail_count++;
                    end
                    if (grad_y !== e.gy)
                    begin
                        $error("grad_y expected %0h got %0h", e.gy, grad_y);
                        fail_count++;
                    end
                    if (grad_z !== e.gz)
                    begin
                        $error("grad_z expected %0h got %0h", e.gz, grad_z);
                        fail_count++;
                    end
                    if (first_index_out !== e.idx1)
                    begin
                        $error("first_index_out expected %0d got %0d", e.idx1, first_index_out);
                        fail_count++;
                    end
                    if (second_index_out !== e.idx2)
                    begin
                        $error("second_index_out expected %0d got %0d", e.idx2,
                               second_index_out);
                        fail_count++;
                    end
                    if (degenerate !== e.deg)
                    begin
                        $error("degenerate expected %0d got %0d", e.deg, degenerate);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                expected_bonds.insert(expected_bonds.size(), predict_bond());
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRANS_LEN: trans_len = cfg_data[19:0];
                    CFG_TRANS_K:   trans_k = cfg_data;
                    CFG_CIS_LEN:   cis_len = cfg_data[19:0];
                    CFG_CIS_K:     cis_k = cfg_data;
                    CFG_WEIGHT:    weight = cfg_data;
                    default:       ;
                endcase
            end
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the harmonic bond block testbench: clock, reset, register setup and bond stimulus.
// Depends on hbeg_pkg, the block and bond_checker.
module testbench;
    import hbeg_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic push = 0;
    logic full;
    logic signed [COORD_W-1:0] first_x = 0, first_y = 0, first_z = 0;
    logic signed [COORD_W-1:0] second_x = 0, second_y = 0, second_z = 0;
    logic cis_bond = 0;
    logic [11:0] first_index = 0, second_index = 0;
    logic empty;
    logic pop = 0;
    logic [ENERGY_W-1:0] bond_energy_out;
    logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;
    logic [11:0] first_index_out, second_index_out;
    logic degenerate;
    int fail_count, pending;
    bit pop_idle_enable = 1;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    harmonic_bond_energy_gradient dut (.*);
    bond_checker checker_inst (.*);

    initial
    begin
        #50_000_000;
        $display("testbench: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        int gap;
        if (pop_idle_enable && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 8);
            pop <= 0;
            repeat (gap) @(posedge clk);
        end
        pop <= 1;
    end

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_bond(input logic [19:0] ax, ay, az, bx, by, bz, input logic cis,
                             input bit may_idle);
        if (may_idle && $urandom_range(0, 9) == 0)
        begin
            push <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        first_x <= ax; first_y <= ay; first_z <= az;
        second_x <= bx; second_y <= by; second_z <= bz;
        cis_bond <= cis;
        first_index <= 12'($urandom);
        second_index <= 12'($urandom);
        push <= 1;
        do @(posedge clk); while (full);
    endtask

    function automatic logic [19:0] coord_rand();
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 8191)) - 20'd4096;
            2: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            default: return 20'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic random_bonds(input int count, input bit may_idle);
        logic [19:0] ax, ay, az;
        for (int i = 0; i < count; i++)
        begin
            ax = coord_rand(); ay = coord_rand(); az = coord_rand();
            if ($urandom_range(0, 1))
                send_bond(ax, ay, az, ax + 20'($urandom_range(0, 8000)) - 20'd4000,
                          ay + 20'($urandom_range(0, 8000)) - 20'd4000,
                          az + 20'($urandom_range(0, 8000)) - 20'd4000,
                          1'($urandom), may_idle);
            else if ($urandom_range(0, 19) == 0)
                send_bond(ax, ay, az, ax, ay, az, 1'($urandom), may_idle);
            else
                send_bond(ax, ay, az, coord_rand(), coord_rand(), coord_rand(),
                          1'($urandom), may_idle);
        end
        push <= 0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_bond(0, 0, 0, 0, 0, 0, 0, 0);
        send_bond(0, 0, 0, 0, 0, 0, 1, 0);
        send_bond(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000, 0, 0);
        send_bond(20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1, 0);
        send_bond(20'd3891, 0, 0, 0, 0, 0, 0, 0);
        send_bond(20'd3021, 0, 0, 0, 0, 0, 1, 0);
        send_bond(20'd1024, 20'd1024, 0, 0, 0, 20'd1024, 0, 0);
        send_bond(0, 20'd1, 0, 0, 0, 0, 1, 0);
        send_bond(20'hFFFFF, 0, 20'd5, 0, 20'd7, 0, 0, 0);
        push <= 0;
        drain();
        write_reg(CFG_TRANS_LEN, 24'hFFFFFF);
        write_reg(CFG_TRANS_K, 24'hFFFFFF);
        write_reg(CFG_CIS_LEN, 24'd0);
        write_reg(CFG_CIS_K, 24'hFFFFFF);
        write_reg(CFG_WEIGHT, 24'hFFFFFF);
        write_reg(cfg_index_t'(3'd7), 24'h123456);
        send_bond(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000, 0, 0);
        send_bond(20'h7FFFF, 0, 0, 20'h80000, 0, 0, 1, 0);
        send_bond(0, 0, 0, 0, 0, 0, 0, 0);
        send_bond(20'd1, 0, 0, 0, 0, 0, 1, 0);
        random_bonds(250, 1);
        drain();
        write_reg(CFG_TRANS_LEN, 24'd0);
        write_reg(CFG_TRANS_K, 24'd0);
        write_reg(CFG_CIS_LEN, 24'h0FFFFF);
        write_reg(CFG_CIS_K, 24'd1);
        write_reg(CFG_WEIGHT, 24'd0);
        random_bonds(200, 1);
        drain();
        for (int p = 0; p < 2; p++)
        begin
            write_reg(CFG_TRANS_LEN, 24'($urandom));
            write_reg(CFG_TRANS_K, 24'($urandom));
            write_reg(CFG_CIS_LEN, 24'($urandom_range(0, 8000)));
            write_reg(CFG_CIS_K, 24'($urandom));
            write_reg(CFG_WEIGHT, 24'($urandom));
            random_bonds(200, 1);
            drain();
        end
        write_reg(CFG_TRANS_LEN, 24'd3891);
        write_reg(CFG_TRANS_K, 24'd227840);
        write_reg(CFG_CIS_LEN, 24'd3021);
        write_reg(CFG_CIS_K, 24'd21760);
        write_reg(CFG_WEIGHT, 24'd65536);
        pop_idle_enable = 0;
        random_bonds(190, 0);
        drain();
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
